[hdl/assert_macros.svh]
// Assertion helpers used by bds_front. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

[hdl/bds_pkg.sv]
`default_nettype none

package bds_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 16384;
    localparam int MAX_CHANNELS = 4;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int LINE_AW      = $clog2(LINE_DEPTH);

    localparam int PIX_W      = 8;
    localparam int PAIR_W     = PIX_W + 1;
    localparam int SUM_W      = PIX_W + 2;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 14;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 15;
    localparam int CHAN_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] in_ch0;
        logic [PIX_W-1:0] in_ch1;
        logic [PIX_W-1:0] in_ch2;
        logic [PIX_W-1:0] in_ch3;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_ch0;
        logic [PIX_W-1:0] out_ch1;
        logic [PIX_W-1:0] out_ch2;
        logic [PIX_W-1:0] out_ch3;
        logic             out_last;
    } out_item_t;

    typedef logic [MAX_CHANNELS-1:0][PAIR_W-1:0] pair_vec_t;

    // Item waiting between the position logic and the output register.
    typedef struct packed {
        pair_vec_t               pair;
        logic                    dbl;
        logic                    last;
        logic [MAX_CHANNELS-1:0] chan_en;
    } stage_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [LINE_AW-1:0] addr;
        pair_vec_t         wdata;
    } line_req_t;

endpackage

`default_nettype wire

[hdl/bds_line_buf.sv]
`default_nettype none

module bds_line_buf (
    input  wire logic               clk,
    input  wire bds_pkg::line_req_t req,
    output bds_pkg::pair_vec_t      rdata
);

    bds_pkg::pair_vec_t mem [bds_pkg::LINE_DEPTH];
    bds_pkg::pair_vec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/bds_front.sv]
`default_nettype none

module bds_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              pix_valid,
    output logic                                   pix_stall,
    input  wire bds_pkg::in_item_t                 pix_data,
    input  wire logic                              out_free,
    output logic                                   stage_valid,
    output bds_pkg::stage_t                        stage,
    output bds_pkg::line_req_t                     line_req
);

    localparam int NCH = bds_pkg::MAX_CHANNELS;
    localparam int PW  = bds_pkg::PIX_W;
    localparam int CW  = bds_pkg::COL_W;
    localparam int RW  = bds_pkg::ROW_W;
    localparam int WW  = bds_pkg::WIDTH_W;
    localparam int HW  = bds_pkg::HEIGHT_W;
    localparam int KW  = bds_pkg::CHAN_W;

    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [KW-1:0] chan_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [NCH-1:0][PW-1:0] left_reg, left_next;

    logic           stage_valid_reg, stage_valid_next;
    bds_pkg::stage_t stage_reg, stage_next;

    logic [WW-1:0]   w_c;
    logic [HW-1:0]   h_c;
    logic [KW-1:0]   ch_c;
    logic [WW-2:0]   dw;
    logic [HW-2:0]   dh;
    logic            w_one, h_one;
    logic            x_ok, y_ok, have, line_ok, emit, accept;
    logic            col_end, row_end;
    logic [NCH-1:0]  chan_en;
    logic [NCH-1:0][PW-1:0] pix_in, pix;
    bds_pkg::pair_vec_t pair;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(1);
            height_reg <= HW'(1);
            chan_reg   <= KW'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bds_pkg::CFG_SRC_WIDTH:     width_reg  <= cfg_data[WW-1:0];
                bds_pkg::CFG_SRC_HEIGHT:    height_reg <= cfg_data[HW-1:0];
                bds_pkg::CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[KW-1:0];
                default:                    ;
            endcase
        end
    end

    // Clamp the registers into their legal ranges.
    always_comb
    begin
        if (width_reg == '0)
            w_c = WW'(1);
        else if (width_reg > WW'(bds_pkg::MAX_WIDTH))
            w_c = WW'(bds_pkg::MAX_WIDTH);
        else
            w_c = width_reg;

        if (height_reg == '0)
            h_c = HW'(1);
        else if (height_reg > HW'(bds_pkg::MAX_HEIGHT))
            h_c = HW'(bds_pkg::MAX_HEIGHT);
        else
            h_c = height_reg;

        if (chan_reg == '0)
            ch_c = KW'(1);
        else if (chan_reg > KW'(NCH))
            ch_c = KW'(NCH);
        else
            ch_c = chan_reg;
    end

    assign dw    = (w_c[WW-1:1] == '0) ? (WW-1)'(1) : w_c[WW-1:1];
    assign dh    = (h_c[HW-1:1] == '0) ? (HW-1)'(1) : h_c[HW-1:1];
    assign w_one = (w_c == WW'(1));
    assign h_one = (h_c == HW'(1));

    assign x_ok = ({1'b0, col_reg} < {dw, 1'b0});
    assign y_ok = ({1'b0, row_reg} < {dh, 1'b0});

    assign pix_in[0] = pix_data.in_ch0;
    assign pix_in[1] = pix_data.in_ch1;
    assign pix_in[2] = pix_data.in_ch2;
    assign pix_in[3] = pix_data.in_ch3;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            chan_en[c] = (KW'(c) < ch_c);
            pix[c]     = chan_en[c] ? pix_in[c] : '0;
            if (w_one)
                pair[c] = {pix[c], 1'b0};
            else
                pair[c] = {1'b0, left_reg[c]} + {1'b0, pix[c]};
        end
    end

    // A narrow image doubles the single column; otherwise odd columns close a pair.
    assign have    = x_ok && (w_one || col_reg[0]);
    assign line_ok = have && y_ok;
    assign emit    = line_ok && (h_one || row_reg[0]);

    assign pix_stall = stage_valid_reg && !out_free;
    assign accept    = pix_valid && !pix_stall;

    assign col_end = (({1'b0, col_reg} + WW'(1)) >= w_c);
    assign row_end = (({1'b0, row_reg} + HW'(1)) >= h_c);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (accept)
        begin
            if (x_ok && !w_one && !col_reg[0])
                left_next = pix;
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        stage_next         = stage_reg;
        stage_next.pair    = pair;
        stage_next.dbl     = h_one;
        stage_next.chan_en = chan_en;
        stage_next.last    = ({1'b0, col_reg[CW-1:1]} == (dw - (WW-1)'(1)))
                          && ({1'b0, row_reg[RW-1:1]} == (dh - (HW-1)'(1)));
        if (accept)
            stage_valid_next = emit;
        else if (out_free)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            left_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            left_reg        <= left_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    // Even rows of an image taller than one row store their pair sums; the read of the same entry is issued on every
    // transaction so the data lines up with the staged item.
    assign line_req.we    = accept && line_ok && !h_one && !row_reg[0];
    assign line_req.re    = accept;
    assign line_req.addr  = col_reg[CW-1:1];
    assign line_req.wdata = pair;

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

`include "assert_macros.svh"

    `ASSERT_CLK(a_stage_hold, stage_valid_reg && !out_free |=> stage_valid_reg && $stable(stage_reg))
    `ASSERT_CLK(a_col_step, accept && !col_end |=> col_reg == $past(col_reg) + CW'(1))
    `ASSERT_NEVER(a_write_and_emit, line_req.we && emit)

endmodule

`default_nettype wire

[hdl/bds_back.sv]
`default_nettype none

module bds_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                stage_valid,
    input  wire bds_pkg::stage_t     stage,
    input  wire bds_pkg::pair_vec_t  rdata,
    output logic                     out_free,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output bds_pkg::out_item_t       res_data
);

    localparam int NCH = bds_pkg::MAX_CHANNELS;
    localparam int PW  = bds_pkg::PIX_W;
    localparam int SW  = bds_pkg::SUM_W;

    logic               out_valid_reg, out_valid_next;
    bds_pkg::out_item_t out_data_reg, out_data_next;
    logic [NCH-1:0][SW-1:0] sum;
    logic [NCH-1:0][PW-1:0] avg;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            if (stage.dbl)
                sum[c] = {stage.pair[c], 1'b0} + SW'(2);
            else
                sum[c] = {1'b0, rdata[c]} + {1'b0, stage.pair[c]} + SW'(2);
            avg[c] = stage.chan_en[c] ? sum[c][SW-1:2] : '0;
        end
    end

    assign out_data_next.out_ch0  = avg[0];
    assign out_data_next.out_ch1  = avg[1];
    assign out_data_next.out_ch2  = avg[2];
    assign out_data_next.out_ch3  = avg[3];
    assign out_data_next.out_last = stage.last;

    assign out_free       = !out_valid_reg || !res_stall;
    assign out_valid_next = out_free ? stage_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

`default_nettype wire

[hdl/box_downsample_2x2.sv]
// Timing: a result passes from the transaction that delivers its lower right tap
// through the position stage register and then the output register before it
// shows on res_valid; back-pressure from res_stall can hold it in either register.
// Throughput: one source pixel per cycle while pix_stall is low; the single-port line
// buffer access per pixel and the one-pass adder stage set that figure.
// Reset: rst_n clears positions, left pixel, valid flags and loads the register
// defaults; the line buffer is not cleared and needs no clearing pass.
`default_nettype none

module box_downsample_2x2 (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           pix_valid,
    output logic                                pix_stall,
    input  wire bds_pkg::in_item_t              pix_data,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output bds_pkg::out_item_t                  res_data
);

    logic                out_free;
    logic                stage_valid;
    bds_pkg::stage_t     stage;
    bds_pkg::line_req_t  line_req;
    bds_pkg::pair_vec_t  rdata;

    bds_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_data    (pix_data),
        .out_free    (out_free),
        .stage_valid (stage_valid),
        .stage       (stage),
        .line_req    (line_req)
    );

    bds_line_buf u_line (
        .clk   (clk),
        .req   (line_req),
        .rdata (rdata)
    );

    bds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .rdata       (rdata),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data)
    );

endmodule

`default_nettype wire
